[hdl/sofp_pkg.sv]
package sofp_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 8;
    localparam int FRAME_LEN_W     = 7;
    localparam int BYTE_IDX_W      = 6;
    localparam int DEF_MAX_PAYLOAD = 64;
    localparam int FIFO_DEPTH      = 4;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [BYTE_W-1:0] DEF_START_BYTE = 8'hAA;

    // Register index is taken from the word address bit of paddr.
    localparam logic REG_START_BYTE = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        BK_CMD,
        BK_RUN,
        BK_WAIT
    } t_bk_state;

    typedef struct packed {
        logic              is_emit;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  aux;
    } t_cmd;

endpackage

[hdl/sofp_front.sv]
module sofp_front #(
    parameter int MAX_PAYLOAD = sofp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sofp_pkg::BYTE_W-1:0] i_start_byte,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sofp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_q_full,
    output logic                        o_push,
    output sofp_pkg::t_cmd              o_cmd
);
    import sofp_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PAYLOAD);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_taken;
    logic [BYTE_W-1:0] r_check;
    logic              w_accept;
    logic              w_oversize;
    logic [LEN_W-1:0]  w_taken_inc;

    assign o_ready     = !i_q_full;
    assign w_accept    = i_valid && o_ready;
    assign w_oversize  = i_rx_byte > MaxLen;
    assign w_taken_inc = r_taken + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                PH_HUNT:  n_phase = (i_rx_byte == i_start_byte) ? PH_TYPE : PH_HUNT;
                PH_TYPE:  n_phase = PH_LEN;
                PH_LEN: begin
                    if (w_oversize) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = (i_rx_byte == '0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA:  n_phase = (w_taken_inc >= r_len) ? PH_CHECK : PH_DATA;
                PH_CHECK: n_phase = PH_HUNT;
                default:  n_phase = (i_rx_byte == i_start_byte) ? PH_TYPE : PH_HUNT;
            endcase
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '{is_emit: 1'b0, data: i_rx_byte, aux: r_taken};
        if (w_accept) begin
            unique case (r_phase)
                PH_DATA: begin
                    o_push = 1'b1;
                end
                PH_CHECK: begin
                    o_push = (i_rx_byte == r_check);
                    o_cmd  = '{is_emit: 1'b1, data: r_type, aux: r_len};
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= '0;
            r_len   <= '0;
            r_taken <= '0;
            r_check <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_accept) begin
                unique case (r_phase)
                    PH_TYPE: begin
                        r_type  <= i_rx_byte;
                        r_check <= i_rx_byte;
                    end
                    PH_LEN: begin
                        r_taken <= '0;
                        if (w_oversize) begin
                            r_check <= '0;
                        end else begin
                            r_len   <= i_rx_byte;
                            r_check <= r_check ^ i_rx_byte;
                        end
                    end
                    PH_DATA: begin
                        r_check <= r_check ^ i_rx_byte;
                        r_taken <= w_taken_inc;
                    end
                    PH_CHECK: begin
                        r_taken <= '0;
                        r_check <= '0;
                    end
                    default: begin
                        r_check <= '0;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/sofp_fifo.sv]
module sofp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sofp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sofp_pkg::t_cmd o_cmd
);
    import sofp_pkg::*;

    localparam int PtrW = $clog2(FIFO_DEPTH);
    localparam int CntW = $clog2(FIFO_DEPTH + 1);

    t_cmd            r_slot [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = r_count == CntW'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("Command queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Command queue read while empty.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(FIFO_DEPTH))
        else $error("Command queue fill count out of range.");

endmodule

[hdl/sofp_back.sv]
module sofp_back #(
    parameter int MAX_PAYLOAD = sofp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  sofp_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sofp_pkg::BYTE_W-1:0]      o_frame_type,
    output logic [sofp_pkg::FRAME_LEN_W-1:0] o_frame_len,
    output logic [sofp_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [sofp_pkg::BYTE_IDX_W-1:0]  o_byte_index,
    output logic                             o_has_payload,
    output logic                             o_last
);
    import sofp_pkg::*;

    localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_bk_state         r_state, n_state;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_k;
    logic [LEN_W-1:0]  w_k_inc;
    logic              w_slot_free;
    logic              w_mem_we;
    logic              w_latch;
    logic              w_load;
    logic              w_is_last;

    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_type;
    logic [FRAME_LEN_W-1:0] r_out_len;
    logic [BYTE_W-1:0]      r_out_byte;
    logic [BYTE_IDX_W-1:0]  r_out_idx;
    logic                   r_out_has;
    logic                   r_out_last;

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_k_inc     = r_k + LEN_W'(1);
    assign w_is_last   = w_k_inc == r_len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CMD: begin
                if (!i_q_empty && i_cmd.is_emit) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_len == '0) begin
                    n_state = w_slot_free ? BK_CMD : BK_RUN;
                end else begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (w_slot_free) begin
                    n_state = w_is_last ? BK_CMD : BK_RUN;
                end
            end
            default: n_state = BK_CMD;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_mem_we = 1'b0;
        w_latch  = 1'b0;
        w_load   = 1'b0;
        unique case (r_state)
            BK_CMD: begin
                o_pop    = !i_q_empty;
                w_mem_we = !i_q_empty && !i_cmd.is_emit;
                w_latch  = !i_q_empty && i_cmd.is_emit;
            end
            BK_RUN:  w_load = (r_len == '0) && w_slot_free;
            BK_WAIT: w_load = w_slot_free;
            default: o_pop  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_cmd.aux[AddrW-1:0]] <= i_cmd.data;
        end
        r_rd_data <= r_mem[r_k[AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CMD;
            r_out_valid <= 1'b0;
            r_type      <= '0;
            r_len       <= '0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (w_latch) begin
                r_type <= i_cmd.data;
                r_len  <= i_cmd.aux;
                r_k    <= '0;
            end else if (w_load && r_state == BK_WAIT) begin
                r_k <= w_k_inc;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_type <= r_type;
            r_out_len  <= r_len[FRAME_LEN_W-1:0];
            if (r_state == BK_WAIT) begin
                r_out_byte <= r_rd_data;
                r_out_idx  <= r_k[BYTE_IDX_W-1:0];
                r_out_has  <= 1'b1;
                r_out_last <= w_is_last;
            end else begin
                r_out_byte <= '0;
                r_out_idx  <= '0;
                r_out_has  <= 1'b0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_type   = r_out_type;
    assign o_frame_len    = r_out_len;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_has_payload  = r_out_has;
    assign o_last         = r_out_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_has |-> r_out_last)
        else $error("Empty-frame beat not marked last.");

    a_no_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != BK_CMD |-> !o_pop)
        else $error("Command popped while a frame is being read out.");

endmodule

[hdl/sof_len_xor_frame_parser.sv]
// Frame parser for a start/type/length/payload/XOR-check byte stream. The front
// end takes one rx byte per cycle whenever the four-entry command queue has room,
// and the back end writes each payload byte it pops from the queue into the
// payload memory. A frame that passes its check is read out one beat at a time,
// each beat a registered memory read followed by the output register load; the
// read-out waits while the output register is full and not taken. The back end
// pops no command while it reads out a frame, so it finishes one frame before it
// stores the next; start, type and length bytes never enter the queue, and a
// check byte enters it only as the emit command of a frame that passes. An empty
// frame gives one beat with has_payload low. Failed frames and oversize lengths
// give no beats. The start byte register sits at address 0 of the APB port.
module sof_len_xor_frame_parser #(
    parameter int MAX_PAYLOAD = sofp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sofp_pkg::PADDR_W-1:0]     paddr,
    input  logic [sofp_pkg::PDATA_W-1:0]     pwdata,
    output logic [sofp_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sofp_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sofp_pkg::BYTE_W-1:0]      o_frame_type,
    output logic [sofp_pkg::FRAME_LEN_W-1:0] o_frame_len,
    output logic [sofp_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [sofp_pkg::BYTE_IDX_W-1:0]  o_byte_index,
    output logic                             o_has_payload,
    output logic                             o_last
);
    import sofp_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic              w_cfg_wr;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_push_cmd;
    t_cmd              w_head_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_START_BYTE) ? PDATA_W'(r_start_byte) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= DEF_START_BYTE;
        end else if (w_cfg_wr && paddr[2] == REG_START_BYTE) begin
            r_start_byte <= pwdata[BYTE_W-1:0];
        end
    end

    sofp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_byte(r_start_byte),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    sofp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_q_full),
        .i_pop  (w_pop),
        .o_empty(w_q_empty),
        .o_cmd  (w_head_cmd)
    );

    sofp_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_type  (o_frame_type),
        .o_frame_len   (o_frame_len),
        .o_payload_byte(o_payload_byte),
        .o_byte_index  (o_byte_index),
        .o_has_payload (o_has_payload),
        .o_last        (o_last)
    );

endmodule

[tb/sv/sof_len_xor_frame_parser_tb.sv]
`timescale 1ns / 1ps

module sof_len_xor_frame_parser_tb;
    import sofp_pkg::*;

    localparam int MAX_PAYLOAD  = DEF_MAX_PAYLOAD;
    localparam int GAP_MAX      = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [BYTE_W-1:0]      ftype;
        logic [FRAME_LEN_W-1:0] flen;
        logic [BYTE_W-1:0]      pbyte;
        logic [BYTE_IDX_W-1:0]  idx;
        logic                   has;
        logic                   last;
    } t_frame_beat;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PADDR_W-1:0]     paddr     = '0;
    logic [PDATA_W-1:0]     pwdata    = '0;
    logic                   i_valid   = 1'b0;
    logic [BYTE_W-1:0]      i_rx_byte = '0;
    logic                   i_ready   = 1'b0;

    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   o_ready;
    logic                   o_valid;
    logic [BYTE_W-1:0]      o_frame_type;
    logic [FRAME_LEN_W-1:0] o_frame_len;
    logic [BYTE_W-1:0]      o_payload_byte;
    logic [BYTE_IDX_W-1:0]  o_byte_index;
    logic                   o_has_payload;
    logic                   o_last;

    sof_len_xor_frame_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_type   (o_frame_type),
        .o_frame_len    (o_frame_len),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_has_payload  (o_has_payload),
        .o_last         (o_last)
    );

    // Shadow copy of the parser state and the start byte register.
    t_phase                 rx_phase;
    logic [BYTE_W-1:0]      cur_type;
    logic [FRAME_LEN_W-1:0] cur_len;
    logic [FRAME_LEN_W-1:0] got_count;
    logic [BYTE_W-1:0]      xor_acc;
    logic [BYTE_W-1:0]      payload_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0]      start_code;

    t_frame_beat       beats_due [$];
    logic [BYTE_W-1:0] tx_bytes [$];

    int send_gap_max   = GAP_MAX;
    int recv_gap_max   = GAP_MAX;
    int send_wait      = 0;
    int recv_wait      = 0;
    int hold_req       = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int cycles         = 0;
    int errors         = 0;
    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int beats_seen     = 0;
    int frames_seen    = 0;
    logic [BYTE_W-1:0] rand_start;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sof_len_xor_frame_parser_tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("MISMATCH cycle %0d: %s", cycles, msg);
        end
    endtask

    function automatic void drop_to_hunt();
        rx_phase  = PH_HUNT;
        got_count = '0;
        xor_acc   = '0;
    endfunction

    function automatic void parse_rx(input logic [BYTE_W-1:0] b);
        t_frame_beat bt;
        case (rx_phase)
            PH_TYPE: begin
                cur_type = b;
                xor_acc  = b;
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    drop_to_hunt();
                end else begin
                    cur_len   = b[FRAME_LEN_W-1:0];
                    xor_acc   = xor_acc ^ b;
                    got_count = '0;
                    rx_phase  = (b == 8'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                if (got_count < MAX_PAYLOAD) begin
                    payload_mem[got_count[BYTE_IDX_W-1:0]] = b;
                end
                xor_acc   = xor_acc ^ b;
                got_count = got_count + 1'b1;
                if (got_count >= cur_len) begin
                    rx_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (b == xor_acc) begin
                    if (cur_len == 0) begin
                        bt       = '0;
                        bt.ftype = cur_type;
                        bt.last  = 1'b1;
                        beats_due.push_back(bt);
                    end else begin
                        for (int k = 0; k < cur_len; k++) begin
                            bt.ftype = cur_type;
                            bt.flen  = cur_len;
                            bt.pbyte = payload_mem[k];
                            bt.idx   = BYTE_IDX_W'(k);
                            bt.has   = 1'b1;
                            bt.last  = (k + 1 == cur_len);
                            beats_due.push_back(bt);
                        end
                    end
                end
                drop_to_hunt();
            end
            default: begin
                if (b == start_code) begin
                    rx_phase = PH_TYPE;
                    xor_acc  = '0;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_valid && o_ready) begin
                parse_rx(i_rx_byte);
                bytes_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    i_valid <= 1'b0;
                    send_wait--;
                end else if (tx_bytes.size() > 0) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= tx_bytes.pop_front();
                    send_wait = $urandom_range(send_gap_max, 0);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_req) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_req;
        end
    end

    always @(posedge i_clk) begin : recv_side
        t_frame_beat got;
        t_frame_beat want;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                got.ftype = o_frame_type;
                got.flen  = o_frame_len;
                got.pbyte = o_payload_byte;
                got.idx   = o_byte_index;
                got.has   = o_has_payload;
                got.last  = o_last;
                beats_seen++;
                if (o_last) begin
                    frames_seen++;
                end
                if (beats_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected beat type %02h len %0d byte %02h idx %0d has %0b last %0b",
                        got.ftype, got.flen, got.pbyte, got.idx, got.has, got.last));
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            {"exp type %02h len %0d byte %02h idx %0d has %0b last %0b, ",
                             "got type %02h len %0d byte %02h idx %0d has %0b last %0b"},
                            want.ftype, want.flen, want.pbyte, want.idx, want.has,
                            want.last, got.ftype, got.flen, got.pbyte, got.idx,
                            got.has, got.last));
                    end
                end
                recv_wait = $urandom_range(recv_gap_max, 0);
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                i_ready <= 1'b0;
                recv_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_rx(input logic [BYTE_W-1:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input int len, input bit good, input int ftype,
                               input bit start_in_body);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] chk;
        t   = (ftype < 0) ? BYTE_W'($urandom) : BYTE_W'(ftype);
        chk = t ^ BYTE_W'(len);
        push_rx(start_code);
        push_rx(t);
        push_rx(BYTE_W'(len));
        for (int k = 0; k < len; k++) begin
            d   = (start_in_body && k == 0) ? start_code : BYTE_W'($urandom);
            chk = chk ^ d;
            push_rx(d);
        end
        if (!good) begin
            chk = chk ^ BYTE_W'(1 << $urandom_range(7, 0));
        end
        push_rx(chk);
    endtask

    task automatic queue_oversize(input logic [BYTE_W-1:0] len);
        push_rx(start_code);
        push_rx(BYTE_W'($urandom));
        push_rx(len);
    endtask

    task automatic queue_random(input int n);
        int goal;
        int pick;
        int r;
        int len;
        goal = bytes_queued + n;
        while (bytes_queued < goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 80) begin
                r   = $urandom_range(19, 0);
                len = (r == 0) ? MAX_PAYLOAD :
                      (r < 4)  ? $urandom_range(MAX_PAYLOAD - 1, 9) : $urandom_range(8, 0);
                queue_frame(len, pick < 68, -1, 1'b0);
            end else if (pick < 87) begin
                queue_oversize(BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1)));
            end else if (pick < 93) begin
                len = $urandom_range(8, 1);
                push_rx(start_code);
                push_rx(BYTE_W'($urandom));
                push_rx(BYTE_W'(len));
                repeat ($urandom_range(len, 0)) push_rx(BYTE_W'($urandom));
            end else begin
                repeat ($urandom_range(3, 1)) push_rx(BYTE_W'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (tx_bytes.size() != 0 || i_valid || beats_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_start_byte(input logic [BYTE_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_START_BYTE, 2'b00};
        pwdata  <= PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        start_code = v;
        @(negedge i_clk);
        if (prdata !== PDATA_W'(v) || pready !== 1'b1) begin
            report_mismatch($sformatf("start byte reads back %08h, pready %0b",
                                      prdata, pready));
        end
    endtask

    initial begin
        rx_phase   = PH_HUNT;
        cur_type   = '0;
        cur_len    = '0;
        got_count  = '0;
        xor_acc    = '0;
        start_code = DEF_START_BYTE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_rx(8'h00);
        push_rx(8'hFF);
        queue_frame(0, 1'b1, 0, 1'b0);
        queue_frame(1, 1'b1, 255, 1'b0);
        queue_oversize(BYTE_W'(MAX_PAYLOAD + 1));
        queue_oversize(8'hFF);
        queue_frame(2, 1'b0, -1, 1'b0);
        queue_frame(2, 1'b1, -1, 1'b1);
        wait_idle();

        write_start_byte(8'h00);
        queue_frame(MAX_PAYLOAD, 1'b1, -1, 1'b0);
        queue_random(75);
        wait_idle();

        write_start_byte(8'hFF);
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_random(75);
        wait_idle();

        rand_start = BYTE_W'($urandom);
        write_start_byte(rand_start);
        recv_gap_max = GAP_MAX;
        hold_req++;
        queue_random(80);
        wait_idle();

        write_start_byte(DEF_START_BYTE);
        send_gap_max = GAP_MAX;
        queue_random(100);
        wait_idle();

        $display("Accepted %0d bytes and checked %0d result beats over %0d frames.",
                 bytes_accepted, beats_seen, frames_seen);
        $display("Start byte ran at 0xAA, 0x00, 0xFF, 0x%02h; one receiver stall of %0d cycles.",
                 rand_start, HOLD_CYCLES);
        if (errors == 0) begin
            $display("sof_len_xor_frame_parser_tb passed");
        end else begin
            $display("sof_len_xor_frame_parser_tb failed");
        end
        $finish;
    end

endmodule
